/* hdl/brms_pkg.sv */
// shared constants and types for the block rms delay line
`timescale 1ns / 1ps
`default_nettype none
package brms_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MAX_BLOCK_DEF = 1024;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned LEVEL_W       = 16;
  localparam int unsigned CHANGE_W      = 17;
  localparam int unsigned Q_DEPTH       = 2;
  localparam int unsigned ADDR_W        = 3;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 11'd512;
  localparam logic REG_BLOCK_SIZE = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } brms_qstat_t;

endpackage
`default_nettype wire

/* hdl/brms_queue.sv */
// short fifo between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module brms_queue import brms_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clear_i,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      brms_qstat_t      stat_o
);
  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [Q_DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (clear_i) begin
      wp_d = '0;
      rp_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/brms_front.sv */
// front part: delay memory, squaring and block accumulation
`timescale 1ns / 1ps
`default_nettype none
module brms_front import brms_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                clear_i,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0]      n_i,
  input  wire logic                                push_i,
  output      logic                                full_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  input  wire brms_qstat_t                         qstat_i,
  output      logic                                qpush_o,
  output      logic [SAMPLE_BITS+2*SAMPLE_BITS+$clog2(MAX_BLOCK):0] qdata_o
);
  localparam int unsigned NW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned AW    = $clog2(MAX_BLOCK);
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_BLOCK);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_ACC  = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  logic [SAMPLE_BITS-1:0] mem_q [MAX_BLOCK];
  logic [SAMPLE_BITS-1:0] rd_q, del_q, mag_q, mag_d;
  logic [2*SAMPLE_BITS-1:0] sq_q;
  logic [SUM_W-1:0] sum_q, sum_d, sum_add;
  logic [AW-1:0] cnt_q, cnt_d;
  logic filled_q, filled_d, zero_q, close_q, is_last;
  logic accept;

  assign full_o  = (state_q != F_IDLE);
  assign accept  = push_i && (state_q == F_IDLE);
  assign is_last = (NW'(cnt_q) == n_i - 1'b1);
  assign mag_d   = sample_in_i[SAMPLE_BITS-1] ? (~sample_in_i + 1'b1) : sample_in_i;
  assign sum_add = sum_q + SUM_W'(sq_q);
  assign qpush_o = (state_q == F_ACC) && !qstat_i.full;
  assign qdata_o = {del_q, close_q, sum_add};

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    filled_d = filled_q;
    sum_d = sum_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          cnt_d = is_last ? '0 : cnt_q + 1'b1;
          filled_d = filled_q || is_last;
          state_d = F_SQ;
        end
      end
      F_SQ: state_d = F_ACC;
      F_ACC: begin
        if (!qstat_i.full) begin
          sum_d = close_q ? '0 : sum_add;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    if (clear_i) begin
      state_d = F_IDLE;
      cnt_d = '0;
      filled_d = 1'b0;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q <= '0;
      filled_q <= 1'b0;
      sum_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      filled_q <= filled_d;
      sum_q <= sum_d;
    end
  end

  // read before write on the same entry gives the old sample
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[cnt_q];
      mem_q[cnt_q] <= sample_in_i;
      mag_q <= mag_d;
      zero_q <= !filled_q;
      close_q <= is_last;
    end
    if (state_q == F_SQ) begin
      sq_q <= mag_q * mag_q;
      del_q <= zero_q ? '0 : rd_q;
    end
  end

`ifndef SYNTHESIS
  a_cnt_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(cnt_q) < n_i) else $error("block counter out of range");
  a_push_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpush_o |-> $past(state_q) == F_SQ || $past(state_q) == F_ACC)
    else $error("queue push without a squared item");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("front state not one-hot");
`endif

endmodule
`default_nettype wire

/* hdl/brms_back.sv */
// back part: iterative divide and square root, result register
`timescale 1ns / 1ps
`default_nettype none
module brms_back import brms_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                clear_i,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0]      n_i,
  input  wire brms_qstat_t                         qstat_i,
  input  wire logic [SAMPLE_BITS+2*SAMPLE_BITS+$clog2(MAX_BLOCK):0] qdata_i,
  output      logic                                qpop_o,
  output      logic                                empty_o,
  input  wire logic                                pop_i,
  output      logic signed [SAMPLE_BITS-1:0]       delayed_sample_o,
  output      logic                                rms_update_o,
  output      logic [LEVEL_W-1:0]                  rms_level_o,
  output      logic signed [CHANGE_W-1:0]          rms_change_o
);
  localparam int unsigned NW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_BLOCK);
  localparam int unsigned RT_W  = SAMPLE_BITS;
  localparam int unsigned SC_W  = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SQRT = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_e;

  bstate_e state_q;
  logic [SAMPLE_BITS-1:0] del_q;
  logic upd_q;
  logic [SUM_W-1:0] quo_q;
  logic [NW-1:0] rem_q;
  logic [NW:0] dtrial;
  logic [2*RT_W-1:0] src_q;
  logic [RT_W+1:0] srem_q;
  logic [RT_W+3:0] sshift, strial;
  logic [RT_W-1:0] root_q, last_q;
  logic signed [CHANGE_W-1:0] chg_q;
  logic [SC_W-1:0] step_q;
  logic ov_q, out_take, load;

  assign qpop_o   = (state_q == B_IDLE) && !qstat_i.empty;
  assign empty_o  = !ov_q;
  assign out_take = pop_i && ov_q;
  assign load     = (state_q == B_EMIT) && (!ov_q || out_take);
  assign dtrial   = {rem_q, quo_q[SUM_W-1]};
  assign sshift   = {srem_q, src_q[2*RT_W-1 -: 2]};
  assign strial   = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q <= 1'b0;
      last_q <= '0;
      chg_q <= '0;
    end else if (clear_i) begin
      state_q <= B_IDLE;
      ov_q <= 1'b0;
      last_q <= '0;
      chg_q <= '0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_take) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!qstat_i.empty) begin
            state_q <= qdata_i[SUM_W] ? B_DIV : B_EMIT;
          end
        end
        B_DIV: begin
          if (step_q == SC_W'(SUM_W - 1)) begin
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (step_q == SC_W'(RT_W - 1)) begin
            state_q <= B_EMIT;
            last_q <= (sshift >= strial) ? {root_q[RT_W-2:0], 1'b1} : {root_q[RT_W-2:0], 1'b0};
            chg_q <= CHANGE_W'((sshift >= strial) ? {root_q[RT_W-2:0], 1'b1}
                                                  : {root_q[RT_W-2:0], 1'b0})
                     - CHANGE_W'(last_q);
          end
        end
        B_EMIT: begin
          if (load) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        del_q <= qdata_i[SUM_W+1 +: SAMPLE_BITS];
        upd_q <= qdata_i[SUM_W];
        quo_q <= qdata_i[SUM_W-1:0];
        rem_q <= '0;
        step_q <= '0;
      end
      B_DIV: begin
        if (dtrial >= {1'b0, n_i}) begin
          rem_q <= NW'(dtrial - {1'b0, n_i});
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= dtrial[NW-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
        if (step_q == SC_W'(SUM_W - 1)) begin
          step_q <= '0;
          // mean fits in twice the sample width
          src_q <= (dtrial >= {1'b0, n_i}) ? {quo_q[2*RT_W-2:0], 1'b1}
                                            : {quo_q[2*RT_W-2:0], 1'b0};
          srem_q <= '0;
          root_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      B_SQRT: begin
        src_q <= {src_q[2*RT_W-3:0], 2'b00};
        step_q <= step_q + 1'b1;
        if (sshift >= strial) begin
          srem_q <= (RT_W + 2)'(sshift - strial);
          root_q <= {root_q[RT_W-2:0], 1'b1};
        end else begin
          srem_q <= sshift[RT_W+1:0];
          root_q <= {root_q[RT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      delayed_sample_o <= del_q;
      rms_update_o <= upd_q;
      rms_level_o <= LEVEL_W'(last_q);
      rms_change_o <= chg_q;
    end
  end

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && rms_level_o[LEVEL_W-1]) |-> rms_level_o[LEVEL_W-2:0] == '0)
    else $error("rms level above full scale");
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SQRT) |-> (RT_W + 2)'(srem_q) <= {1'b0, root_q, 1'b0})
    else $error("square root remainder too large");
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && $past(state_q) != B_DIV) |-> $past(state_q) == B_IDLE)
    else $error("divide started outside idle");
`endif

endmodule
`default_nettype wire

/* hdl/block_rms_delay_line.sv */
// top level of the block rms delay line with its register port
//
// channel   direction  handshake          payload
// input     in         push / full        sample_in_i
// result    out        empty / pop        delayed_sample_o rms_update_o rms_level_o rms_change_o
// config    in         psel penable pwrite paddr pwdata prdata
//
// an item not closing a block is squared, summed, queued and then held in the result register
// the front takes a new item only once the last has left its accumulate state
// and stalls when the queue is full; an item that closes a block also goes through
// the bit-serial divider and square root in the back part
// reset and every block_size write clear the delay, sum and rms state
// a two-entry queue and the result register let either side stall on its own
`timescale 1ns / 1ps
`default_nettype none
module block_rms_delay_line import brms_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic signed [SAMPLE_BITS-1:0] delayed_sample_o,
  output      logic                          rms_update_o,
  output      logic [LEVEL_W-1:0]            rms_level_o,
  output      logic signed [CHANGE_W-1:0]    rms_change_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  localparam int unsigned NW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned REC_W = SAMPLE_BITS + 1 + 2 * SAMPLE_BITS + $clog2(MAX_BLOCK);

  logic [CFG_W-1:0] bs_q;
  logic [NW-1:0] n;
  logic cfg_we;
  logic qpush, qpop;
  logic [REC_W-1:0] qwdata, qrdata;
  brms_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BLOCK_SIZE);
  assign prdata = (paddr[2] == REG_BLOCK_SIZE) ? 32'(bs_q) : '0;

  always_comb begin
    if (bs_q == '0) begin
      n = NW'(1);
    end else if (32'(bs_q) > 32'(MAX_BLOCK)) begin
      n = NW'(MAX_BLOCK);
    end else begin
      n = NW'(bs_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BLOCK_SIZE_RST;
    end else if (cfg_we) begin
      bs_q <= pwdata[CFG_W-1:0];
    end
  end

  brms_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we),
    .n_i         (n),
    .push_i      (push),
    .full_o      (full),
    .sample_in_i (sample_in_i),
    .qstat_i     (qstat),
    .qpush_o     (qpush),
    .qdata_o     (qwdata)
  );

  brms_queue #(.WIDTH(REC_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we),
    .push_i  (qpush),
    .wdata_i (qwdata),
    .pop_i   (qpop),
    .rdata_o (qrdata),
    .stat_o  (qstat)
  );

  brms_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clear_i          (cfg_we),
    .n_i              (n),
    .qstat_i          (qstat),
    .qdata_i          (qrdata),
    .qpop_o           (qpop),
    .empty_o          (empty),
    .pop_i            (pop),
    .delayed_sample_o (delayed_sample_o),
    .rms_update_o     (rms_update_o),
    .rms_level_o      (rms_level_o),
    .rms_change_o     (rms_change_o)
  );

endmodule
`default_nettype wire
